[rtl/tkrll_pkg.sv]
`default_nettype none
package tkrll_pkg;

   localparam int SCORE_W  = 31;
   localparam int ID_W     = 31;
   localparam int PERIOD_W = 10;
   localparam int VOL_W    = 24;
   localparam int CAP_W    = 25;
   localparam int RANK_W   = 7;

   localparam logic [1:0] CRIT_VOLUME   = 2'd0;
   localparam logic [1:0] CRIT_PER_LANE = 2'd1;
   localparam logic [1:0] CRIT_RATIO    = 2'd2;

   typedef struct packed {
      logic [SCORE_W-1:0]  score;
      logic [ID_W-1:0]     link;
      logic [ID_W-1:0]     from_node;
      logic [ID_W-1:0]     to_node;
      logic [PERIOD_W-1:0] period;
      logic [VOL_W-1:0]    volume;
      logic [CAP_W-1:0]    capacity;
   } entry_type;

endpackage
`default_nettype wire

[rtl/top_k_ranked_link_load.sv]
`default_nettype none
// Ranked table of the highest-scoring link records.
// Input channel req_*: mode 0 offers a record, mode 1 reads the entry at req_rank.
// Result channel rsp_*: one transfer per read, none per offer.
// An offer holds req_ready low from its transfer until it is done; it makes
// up to two passes through one 48-bit radix-2 divider: one when a lane override
// applies, one for the per-lane or ratio score.
// The period capacity is a reciprocal multiplication in state S_PRE; the last
// step lets every cell of the chain compare and shift.
// An offer with a zero volume, hourly capacity or period index, a period index above MAX_PERIODS,
// or zero capacity drops out early with no change. rsp_valid rises after a read passes S_READ.
// Only one item is in work at a time; req_ready is low meanwhile.
// A stalled result waits in the output register; req_ready stays low until it leaves.
// Reset empties the table and sets csr criterion to volume.
// csr_wdata written while idle selects the score criterion.
module top_k_ranked_link_load #(
   parameter int TABLE_DEPTH = 100,
   parameter int MAX_PERIODS = 1023
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         csr_we,
   input  wire  [1:0]  csr_wdata,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire         req_mode,
   input  wire  [30:0] req_link_id,
   input  wire  [30:0] req_from_node,
   input  wire  [30:0] req_to_node,
   input  wire  [9:0]  req_period_index,
   input  wire  [23:0] req_volume,
   input  wire  [15:0] req_hourly_capacity,
   input  wire  [16:0] req_period_seconds,
   input  wire  [3:0]  req_thru_lanes,
   input  wire         req_override_valid,
   input  wire  [3:0]  req_override_lanes,
   input  wire  [6:0]  req_rank,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic        rsp_entry_valid,
   output logic [30:0] rsp_score,
   output logic [30:0] rsp_entry_link,
   output logic [30:0] rsp_entry_from,
   output logic [30:0] rsp_entry_to,
   output logic [9:0]  rsp_entry_period,
   output logic [23:0] rsp_entry_volume,
   output logic [24:0] rsp_entry_capacity
);
   import tkrll_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0, S_CAP = 3'd1, S_TOD = 3'd2,
                          S_SCORE = 3'd3, S_INS = 3'd4, S_READ = 3'd5,
                          S_PRE = 3'd6;

   // ceil(2^38 / 225): divide by 16, then by 225
   localparam logic [30:0] RECIP_225 = 31'd1221679587;

   logic [2:0]  st_ff, st_in;
   logic [1:0]  crit_ff;
   entry_type   cand_ff, cand_in;
   logic [47:0] cap_ff, cap_in, tcap_ff, tcap_in;
   logic [3:0]  lanes_ff, lanes_in, olanes_ff, olanes_in;
   logic        ovalid_ff, ovalid_in;
   logic [6:0]  rank_ff, rank_in;
   logic        ins;
   logic        dstart;
   logic [47:0] dnum, dden, dq;
   logic        ddone;
   logic [47:0] mul_ff, mul_in;
   logic [59:0] cap_prod;
   entry_type   rsp_ff, rsp_in;
   logic        rv_ff, rv_in;
   logic [47:0] score_w;

   entry_type   ent [TABLE_DEPTH];
   logic        tk  [TABLE_DEPTH];

   tkrll_div u_div (
      .clock(clock), .reset(reset), .start(dstart), .dividend(dnum),
      .divisor(dden), .done(ddone), .quotient(dq)
   );

   genvar g;
   generate
      for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
         if (g == 0) begin : g_first
            tkrll_cell u_cell (
               .clock(clock), .reset(reset), .ins(ins), .cand(cand_ff),
               .prev_taken(1'b0), .prev_entry('0), .taken(tk[g]), .entry(ent[g])
            );
         end else begin : g_rest
            tkrll_cell u_cell (
               .clock(clock), .reset(reset), .ins(ins), .cand(cand_ff),
               .prev_taken(tk[g-1]), .prev_entry(ent[g-1]), .taken(tk[g]),
               .entry(ent[g])
            );
         end
      end
   endgenerate

   assign req_ready = (st_ff == S_IDLE) && !rv_ff;

   always_comb begin
      st_in     = st_ff;
      cand_in   = cand_ff;
      cap_in    = cap_ff;
      tcap_in   = tcap_ff;
      lanes_in  = lanes_ff;
      olanes_in = olanes_ff;
      ovalid_in = ovalid_ff;
      rank_in   = rank_ff;
      mul_in    = mul_ff;
      rsp_in    = rsp_ff;
      rv_in     = rv_ff;
      ins       = 1'b0;
      dstart    = 1'b0;
      dnum      = '0;
      dden      = '0;
      score_w   = '0;
      cap_prod  = 60'(mul_ff[32:4]) * 60'(RECIP_225);
      if (rv_ff && rsp_ready) rv_in = 1'b0;
      unique case (st_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               rank_in   = req_rank;
               cand_in.link      = req_link_id;
               cand_in.from_node = req_from_node;
               cand_in.to_node   = req_to_node;
               cand_in.period    = req_period_index;
               cand_in.volume    = req_volume;
               cand_in.score     = '0;
               cand_in.capacity  = '0;
               lanes_in  = (req_thru_lanes == 4'd0) ? 4'd1 : req_thru_lanes;
               olanes_in = req_override_lanes;
               ovalid_in = req_override_valid;
               mul_in    = 48'(req_hourly_capacity) * 48'(req_period_seconds) + 48'd1800;
               if (req_mode) st_in = S_READ;
               else if (req_volume != '0 && req_hourly_capacity != '0 &&
                        req_period_index != '0 &&
                        32'(req_period_index) <= MAX_PERIODS)
                  st_in = S_PRE;
            end
         end
         S_PRE: begin
            cap_in  = 48'(cap_prod[59:38]);
            tcap_in = 48'(cap_prod[59:38]);
            st_in   = S_CAP;
         end
         S_CAP: begin
            if (cap_ff == '0) st_in = S_IDLE;
            else if (ovalid_ff) begin
               dstart = 1'b1;
               dnum   = 48'(cap_ff[24:0]) * 48'(olanes_ff) + 48'(lanes_ff[3:1]);
               dden   = 48'(lanes_ff);
               st_in  = S_TOD;
            end else begin
               st_in = S_SCORE;
               mul_in = '0;
            end
         end
         S_TOD: begin
            if (ddone) begin
               tcap_in = (dq == '0) ? (cap_ff >> 1) : dq;
               lanes_in = olanes_ff;
               st_in = S_SCORE;
               mul_in = '0;
            end
         end
         S_SCORE: begin
            if (mul_ff == '0) begin
               mul_in = 48'd1;
               case (crit_ff)
                  CRIT_PER_LANE: begin
                     if (lanes_ff == '0) st_in = S_IDLE;
                     else begin
                        dstart = 1'b1;
                        dnum = 48'(cand_ff.volume) + 48'(lanes_ff[3:1]);
                        dden = 48'(lanes_ff);
                     end
                  end
                  CRIT_RATIO: begin
                     if (tcap_ff == '0) st_in = S_IDLE;
                     else begin
                        dstart = 1'b1;
                        dnum = 48'(cand_ff.volume) * 48'd100 + (tcap_ff >> 1);
                        dden = tcap_ff;
                     end
                  end
                  CRIT_VOLUME: begin
                     cand_in.score = 31'(cand_ff.volume);
                     cand_in.capacity = (tcap_ff > 48'h1FFFFFF) ? 25'h1FFFFFF
                                                                : tcap_ff[24:0];
                     st_in = S_INS;
                  end
                  default: st_in = S_IDLE;
               endcase
            end else if (ddone) begin
               score_w = dq;
               cand_in.score = (score_w > 48'h7FFFFFFF) ? 31'h7FFFFFFF : score_w[30:0];
               cand_in.capacity = (tcap_ff > 48'h1FFFFFF) ? 25'h1FFFFFF : tcap_ff[24:0];
               st_in = (score_w == '0) ? S_IDLE : S_INS;
            end
         end
         S_INS: begin
            ins   = 1'b1;
            st_in = S_IDLE;
         end
         S_READ: begin
            rsp_in = '0;
            for (int i = 0; i < TABLE_DEPTH; i++)
               if (32'(rank_ff) == i) rsp_in = ent[i];
            rv_in = 1'b1;
            st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      cand_ff   <= cand_in;
      cap_ff    <= cap_in;
      tcap_ff   <= tcap_in;
      lanes_ff  <= lanes_in;
      olanes_ff <= olanes_in;
      ovalid_ff <= ovalid_in;
      rank_ff   <= rank_in;
      mul_ff    <= mul_in;
      rsp_ff    <= rsp_in;
      if (reset) begin
         st_ff   <= S_IDLE;
         rv_ff   <= 1'b0;
         crit_ff <= CRIT_VOLUME;
      end else begin
         st_ff <= st_in;
         rv_ff <= rv_in;
         if (csr_we) crit_ff <= csr_wdata;
      end
   end

   assign rsp_valid          = rv_ff;
   assign rsp_entry_valid    = rsp_ff.score != '0;
   assign rsp_score          = rsp_ff.score;
   assign rsp_entry_link     = rsp_ff.link;
   assign rsp_entry_from     = rsp_ff.from_node;
   assign rsp_entry_to       = rsp_ff.to_node;
   assign rsp_entry_period   = rsp_ff.period;
   assign rsp_entry_volume   = rsp_ff.volume;
   assign rsp_entry_capacity = rsp_ff.capacity;
endmodule
`default_nettype wire

[rtl/tkrll_div.sv]
`default_nettype none
module tkrll_div (
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   input  wire  [47:0] dividend,
   input  wire  [47:0] divisor,
   output logic        done,
   output logic [47:0] quotient
);
   logic [47:0] rem_ff, rem_in, quo_ff, quo_in, den_ff, den_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [48:0] trial;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[47]} - {1'b0, den_ff};
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         den_in  = divisor;
         cnt_in  = 6'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[48]) begin
            rem_in = trial[47:0];
            quo_in = {quo_ff[46:0], 1'b1};
         end else begin
            rem_in = {rem_ff[46:0], quo_ff[47]};
            quo_in = {quo_ff[46:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd47) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule
`default_nettype wire

[rtl/tkrll_cell.sv]
`default_nettype none
module tkrll_cell (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    ins,
   input  tkrll_pkg::entry_type   cand,
   input  wire                    prev_taken,
   input  tkrll_pkg::entry_type   prev_entry,
   output logic                   taken,
   output tkrll_pkg::entry_type   entry
);
   import tkrll_pkg::*;
   entry_type ent_ff, ent_in;
   logic      here;

   always_comb begin
      here   = cand.score > ent_ff.score;
      taken  = prev_taken | here;
      ent_in = ent_ff;
      if (ins) begin
         if (prev_taken) ent_in = prev_entry;
         else if (here)  ent_in = cand;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) ent_ff <= '0;
      else       ent_ff <= ent_in;
   end

   assign entry = ent_ff;
endmodule
`default_nettype wire
